// ===== rtl/psi_pkg.sv =====
// Shared types, field codes and fixed-point helpers for the particle state integrator.
// Used by every module of the block; depends on nothing else.
package psi_pkg;

  localparam int NUM_PARTICLES_DEF = 256;
  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // Field select codes of a write item.
  localparam logic [4:0] F_AGE        = 5'd0;
  localparam logic [4:0] F_LIFE       = 5'd1;
  localparam logic [4:0] F_POS_X      = 5'd2;
  localparam logic [4:0] F_POS_Z      = 5'd4;
  localparam logic [4:0] F_VEL_X      = 5'd5;
  localparam logic [4:0] F_VEL_Z      = 5'd7;
  localparam logic [4:0] F_COL_R      = 5'd8;
  localparam logic [4:0] F_COL_B      = 5'd10;
  localparam logic [4:0] F_RATE_R     = 5'd11;
  localparam logic [4:0] F_RATE_B     = 5'd13;
  localparam logic [4:0] F_ALPHA      = 5'd14;
  localparam logic [4:0] F_ALPHA_RATE = 5'd15;
  localparam logic [4:0] F_SIZE       = 5'd16;
  localparam logic [4:0] F_SIZE_RATE  = 5'd17;
  localparam logic [4:0] F_STOP       = 5'd18;
  localparam logic [4:0] F_SHOW_HIDE  = 5'd19;
  localparam logic [4:0] F_SHOW       = 5'd20;
  localparam logic [4:0] F_FLAGS      = 5'd21;

  // Bit positions inside the stored flag word.
  localparam int FLAG_STOP_BIT = 0;
  localparam int FLAG_SH_BIT   = 1;
  localparam int FLAG_SHOW_BIT = 2;

  // One queued item, as classified by the front end.
  typedef struct packed {
    logic              cmd;
    logic [7:0]        idx;
    logic              in_range;
    logic [4:0]        sel;
    logic signed [31:0] value;
    logic [15:0]       dt;
    logic signed [31:0] att_x;
    logic signed [31:0] att_y;
    logic signed [31:0] att_z;
    logic              att_en;
    logic signed [31:0] strength;
  } item_t;

  // One result item.
  typedef struct packed {
    logic              alive;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] red;
    logic signed [31:0] green;
    logic signed [31:0] blue;
    logic signed [31:0] opacity;
    logic signed [31:0] size;
  } result_t;

  // Saturate a grown sum to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -35'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Sign-extend a Q16.16 value for a saturating add.
  function automatic logic signed [34:0] ext35(input logic signed [31:0] v);
    return 35'(v);
  endfunction

endpackage

// ===== rtl/psi_front.sv =====
// Front end of the particle state integrator: accepts and classifies items
// and holds them in a short queue for the back end. Depends on psi_pkg.
module psi_front import psi_pkg::*; #(
  parameter int NUM_PARTICLES = NUM_PARTICLES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_command,
  input  logic [7:0]         in_particle_index,
  input  logic [4:0]         in_field_select,
  input  logic signed [31:0] in_field_value,
  input  logic [15:0]        in_time_step,
  input  logic signed [31:0] in_attractor_x,
  input  logic signed [31:0] in_attractor_y,
  input  logic signed [31:0] in_attractor_z,
  input  logic               in_attract_enable,
  input  logic signed [31:0] in_attract_strength,
  input  logic               pop,
  output logic               q_valid,
  output item_t              q_item
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t           q_mem [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            push;
  logic            do_pop;
  item_t           new_item;

  // Classify the incoming item: the index check is done once, here.
  always_comb begin
    new_item.cmd      = in_command;
    new_item.idx      = in_particle_index;
    new_item.in_range = 32'(in_particle_index) < 32'(NUM_PARTICLES);
    new_item.sel      = in_field_select;
    new_item.value    = in_field_value;
    new_item.dt       = in_time_step;
    new_item.att_x    = in_attractor_x;
    new_item.att_y    = in_attractor_y;
    new_item.att_z    = in_attractor_z;
    new_item.att_en   = in_attract_enable;
    new_item.strength = in_attract_strength;
  end

  assign busy    = (count_r == CW'(QUEUE_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (count_r != '0);
  assign do_pop  = pop && q_valid;
  assign q_item  = q_mem[rd_ptr_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= new_item;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/psi_norm.sv =====
// Direction normalizer: sum of squares, bit-serial square root and three
// restoring divider lanes. Depends on psi_pkg.
module psi_norm import psi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [32:0] diff_x,
  input  logic signed [32:0] diff_y,
  input  logic signed [32:0] diff_z,
  output logic               done,
  output logic signed [17:0] unit_x,
  output logic signed [17:0] unit_y,
  output logic signed [17:0] unit_z
);

  typedef enum logic [2:0] {N_IDLE, N_SQ, N_SQRT, N_DIV, N_OUT} nstate_t;

  nstate_t            state_r;
  logic [4:0]         cnt_r;
  logic [30:0]        mag_r [3];
  logic               neg_r [3];
  logic [61:0]        sq_r;
  logic [63:0]        n_r;
  logic [63:0]        res_r;
  logic [63:0]        bit_r;
  logic [34:0]        rem_r [3];
  logic [16:0]        q_r [3];
  logic               done_r;
  logic signed [17:0] unit_r [3];

  logic signed [32:0] diff [3];
  logic [31:0]        m_abs [3];
  logic               big;
  logic [64:0]        trial;
  logic               root_ge;
  logic [32:0]        len;
  logic               div_ge [3];

  assign diff[0] = diff_x;
  assign diff[1] = diff_y;
  assign diff[2] = diff_z;

  // Magnitudes of the differences; halve all if any reaches 2^31.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_abs[i] = diff[i][32] ? 32'(-diff[i]) : 32'(diff[i]);
    end
    big = m_abs[0][31] | m_abs[1][31] | m_abs[2][31];
  end

  // One square-root step and one divide step per lane.
  assign trial   = 65'(res_r) + 65'(bit_r);
  assign root_ge = 65'(n_r) >= trial;
  assign len     = res_r[32:0];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      div_ge[i] = rem_r[i] >= 35'(len);
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              mag_r[i] <= big ? m_abs[i][31:1] : m_abs[i][30:0];
              neg_r[i] <= diff[i][32];
            end
            n_r     <= '0;
            cnt_r   <= '0;
            state_r <= N_SQ;
          end
        end
        N_SQ: begin
          if (cnt_r < 5'd3) begin
            sq_r <= 62'(mag_r[cnt_r[1:0]]) * 62'(mag_r[cnt_r[1:0]]);
          end
          if (cnt_r != '0) begin
            n_r <= n_r + 64'(sq_r);
          end
          if (cnt_r == 5'd3) begin
            res_r   <= '0;
            bit_r   <= 64'h4000_0000_0000_0000;
            cnt_r   <= '0;
            state_r <= N_SQRT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        N_SQRT: begin
          if (root_ge) begin
            n_r   <= n_r - trial[63:0];
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'd31) begin
            for (int i = 0; i < 3; i++) begin
              rem_r[i] <= 35'(mag_r[i]);
              q_r[i]   <= '0;
            end
            cnt_r   <= '0;
            state_r <= N_DIV;
          end
        end
        N_DIV: begin
          for (int i = 0; i < 3; i++) begin
            q_r[i]   <= {q_r[i][15:0], div_ge[i]};
            rem_r[i] <= (div_ge[i] ? rem_r[i] - 35'(len) : rem_r[i]) << 1;
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'd16) begin
            state_r <= N_OUT;
          end
        end
        N_OUT: begin
          // A zero length gives a zero direction.
          for (int i = 0; i < 3; i++) begin
            if (len == '0) begin
              unit_r[i] <= '0;
            end else if (neg_r[i]) begin
              unit_r[i] <= -signed'(18'(q_r[i]));
            end else begin
              unit_r[i] <= signed'(18'(q_r[i]));
            end
          end
          done_r  <= 1'b1;
          state_r <= N_IDLE;
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign unit_x = unit_r[0];
  assign unit_y = unit_r[1];
  assign unit_z = unit_r[2];

endmodule

// ===== rtl/psi_back.sv =====
// Back end of the particle state integrator: particle tables, shared
// multiplier and the update sequencer. Depends on psi_pkg and psi_norm.
module psi_back import psi_pkg::*; #(
  parameter int NUM_PARTICLES = NUM_PARTICLES_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    pop,
  output logic    res_valid,
  output result_t res
);

  localparam int AW = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;

  // Operation steps of an update, each one product and one accumulate.
  localparam logic [3:0] OP_POS0     = 4'd0;
  localparam logic [3:0] OP_POS2     = 4'd2;
  localparam logic [3:0] OP_DAMP0    = 4'd3;
  localparam logic [3:0] OP_DAMP2    = 4'd5;
  localparam logic [3:0] OP_STR_DAMP = 4'd6;
  localparam logic [3:0] OP_K        = 4'd7;
  localparam logic [3:0] OP_ATT0     = 4'd8;
  localparam logic [3:0] OP_ATT2     = 4'd10;
  localparam logic [3:0] OP_COL0     = 4'd11;
  localparam logic [3:0] OP_COL2     = 4'd13;
  localparam logic [3:0] OP_ALPHA    = 4'd14;
  localparam logic [3:0] OP_SIZE     = 4'd15;

  typedef enum logic [2:0] {
    B_IDLE, B_FETCH, B_CHECK, B_MUL, B_ACC, B_NORM_GO, B_NORM_WAIT, B_WB
  } bstate_t;

  // Particle tables.
  logic [31:0] age_mem   [NUM_PARTICLES];
  logic [31:0] life_mem  [NUM_PARTICLES];
  logic [95:0] pos_mem   [NUM_PARTICLES];
  logic [95:0] vel_mem   [NUM_PARTICLES];
  logic [95:0] col_mem   [NUM_PARTICLES];
  logic [95:0] rate_mem  [NUM_PARTICLES];
  logic [63:0] alpha_mem [NUM_PARTICLES];
  logic [63:0] size_mem  [NUM_PARTICLES];
  logic [2:0]  flag_mem  [NUM_PARTICLES];

  logic [31:0] rd_age_r;
  logic [31:0] rd_life_r;
  logic [95:0] rd_pos_r;
  logic [95:0] rd_vel_r;
  logic [95:0] rd_col_r;
  logic [95:0] rd_rate_r;
  logic [63:0] rd_alpha_r;
  logic [63:0] rd_size_r;
  logic [2:0]  rd_flag_r;

  bstate_t             state_r;
  item_t               it_r;
  logic [3:0]          op_r;
  logic signed [65:0]  prod_r;
  logic signed [31:0]  age_w_r;
  logic signed [31:0]  pos_r [3];
  logic signed [31:0]  vel_r [3];
  logic signed [31:0]  col_r [3];
  logic signed [31:0]  rate_r [3];
  logic signed [31:0]  al_r;
  logic signed [31:0]  alr_r;
  logic signed [31:0]  sz_r;
  logic signed [31:0]  szr_r;
  logic signed [31:0]  str_r;
  logic signed [31:0]  k_r;
  logic signed [17:0]  u_r [3];
  logic                stop_r;
  logic                sh_r;
  logic                show_r;
  logic                res_valid_r;
  result_t             res_r;

  logic [AW-1:0]       addr;
  logic [1:0]          lane;
  logic signed [32:0]  dt33;
  logic signed [32:0]  opa;
  logic signed [32:0]  opb;
  logic signed [33:0]  mq_w;
  logic signed [34:0]  mq35;
  logic signed [34:0]  age_dt;
  logic                dead;
  logic signed [31:0]  a_up;
  logic signed [31:0]  a_dn;
  logic signed [31:0]  alpha_nxt;
  logic                show_nxt;
  logic [1:0]          c_pos;
  logic [1:0]          c_vel;
  logic [1:0]          c_col;
  logic [1:0]          c_rate;
  logic                norm_start;
  logic                norm_done;
  logic signed [17:0]  unit_x;
  logic signed [17:0]  unit_y;
  logic signed [17:0]  unit_z;

  assign addr   = AW'(it_r.idx);
  assign dt33   = signed'({17'd0, it_r.dt});
  assign pop    = (state_r == B_IDLE) && q_valid;
  assign c_pos  = 2'(it_r.sel - F_POS_X);
  assign c_vel  = 2'(it_r.sel - F_VEL_X);
  assign c_col  = 2'(it_r.sel - F_COL_R);
  assign c_rate = 2'(it_r.sel - F_RATE_R);

  // Expiry test on the freshly read age and lifetime.
  assign age_dt = ext35(signed'(rd_age_r)) + 35'(dt33);
  assign dead   = age_dt >= ext35(signed'(rd_life_r));

  // Component lane of a vector step.
  always_comb begin
    case (op_r) inside
      [OP_POS0:OP_POS2]:   lane = 2'(op_r - OP_POS0);
      [OP_DAMP0:OP_DAMP2]: lane = 2'(op_r - OP_DAMP0);
      [OP_ATT0:OP_ATT2]:   lane = 2'(op_r - OP_ATT0);
      [OP_COL0:OP_COL2]:   lane = 2'(op_r - OP_COL0);
      default:             lane = 2'd0;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    opa = '0;
    opb = dt33;
    case (op_r) inside
      [OP_POS0:OP_POS2], [OP_DAMP0:OP_DAMP2]: opa = 33'(vel_r[lane]);
      OP_STR_DAMP, OP_K:                      opa = 33'(str_r);
      [OP_ATT0:OP_ATT2]: begin
        opa = 33'(u_r[lane]);
        opb = 33'(k_r);
      end
      [OP_COL0:OP_COL2]:                      opa = 33'(rate_r[lane]);
      OP_ALPHA:                               opa = 33'(alr_r);
      OP_SIZE:                                opa = 33'(szr_r);
      default:                                opa = '0;
    endcase
  end

  // Product rounded toward minus infinity to Q16.16.
  assign mq_w = prod_r[49:16];
  assign mq35 = 35'(mq_w);

  // Alpha step, with the show-hide ramp and clamp.
  always_comb begin
    a_up      = sat32(ext35(al_r) + mq35);
    a_dn      = sat32(ext35(al_r) - mq35);
    show_nxt  = show_r;
    alpha_nxt = a_up;
    if (sh_r) begin
      if (show_r) begin
        if (a_up >= ONE_Q) begin
          alpha_nxt = ONE_Q;
          show_nxt  = 1'b0;
        end else if (a_up < 0) begin
          alpha_nxt = '0;
        end
      end else begin
        alpha_nxt = a_dn;
        if (a_dn < 0) begin
          alpha_nxt = '0;
        end else if (a_dn > ONE_Q) begin
          alpha_nxt = ONE_Q;
        end
      end
    end
  end

  assign norm_start = (state_r == B_NORM_GO);

  psi_norm u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (norm_start),
    .diff_x (33'(it_r.att_x) - 33'(pos_r[0])),
    .diff_y (33'(it_r.att_y) - 33'(pos_r[1])),
    .diff_z (33'(it_r.att_z) - 33'(pos_r[2])),
    .done   (norm_done),
    .unit_x (unit_x),
    .unit_y (unit_y),
    .unit_z (unit_z)
  );

  // Table reads, field writes, expiry marks and write-back.
  always_ff @(posedge clk) begin
    case (state_r)
      B_FETCH: begin
        rd_age_r   <= age_mem[addr];
        rd_life_r  <= life_mem[addr];
        rd_pos_r   <= pos_mem[addr];
        rd_vel_r   <= vel_mem[addr];
        rd_col_r   <= col_mem[addr];
        rd_rate_r  <= rate_mem[addr];
        rd_alpha_r <= alpha_mem[addr];
        rd_size_r  <= size_mem[addr];
        rd_flag_r  <= flag_mem[addr];
        if (it_r.cmd == CMD_WRITE && it_r.in_range) begin
          case (it_r.sel) inside
            F_AGE:                 age_mem[addr] <= it_r.value;
            F_LIFE:                life_mem[addr] <= it_r.value;
            [F_POS_X:F_POS_Z]:     pos_mem[addr][c_pos*32 +: 32] <= it_r.value;
            [F_VEL_X:F_VEL_Z]:     vel_mem[addr][c_vel*32 +: 32] <= it_r.value;
            [F_COL_R:F_COL_B]:     col_mem[addr][c_col*32 +: 32] <= it_r.value;
            [F_RATE_R:F_RATE_B]:   rate_mem[addr][c_rate*32 +: 32] <= it_r.value;
            F_ALPHA:               alpha_mem[addr][31:0] <= it_r.value;
            F_ALPHA_RATE:          alpha_mem[addr][63:32] <= it_r.value;
            F_SIZE:                size_mem[addr][31:0] <= it_r.value;
            F_SIZE_RATE:           size_mem[addr][63:32] <= it_r.value;
            F_STOP:                flag_mem[addr][FLAG_STOP_BIT] <= it_r.value[0];
            F_SHOW_HIDE:           flag_mem[addr][FLAG_SH_BIT] <= it_r.value[0];
            F_SHOW:                flag_mem[addr][FLAG_SHOW_BIT] <= it_r.value[0];
            F_FLAGS:               flag_mem[addr] <= it_r.value[2:0];
            default: ;
          endcase
        end
      end
      B_CHECK: begin
        if (dead) begin
          age_mem[addr] <= -ONE_Q;
        end
      end
      B_WB: begin
        age_mem[addr]   <= age_w_r;
        pos_mem[addr]   <= {pos_r[2], pos_r[1], pos_r[0]};
        vel_mem[addr]   <= {vel_r[2], vel_r[1], vel_r[0]};
        col_mem[addr]   <= {col_r[2], col_r[1], col_r[0]};
        alpha_mem[addr] <= {alr_r, al_r};
        size_mem[addr]  <= {szr_r, sz_r};
        flag_mem[addr]  <= {show_r, sh_r, stop_r};
      end
      default: ;
    endcase
  end

  // Update sequencer and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      res_valid_r <= 1'b0;
      op_r        <= OP_POS0;
    end else begin
      res_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            it_r    <= q_item;
            state_r <= B_FETCH;
          end
        end
        B_FETCH: begin
          if (it_r.cmd == CMD_WRITE) begin
            state_r <= B_IDLE;
          end else if (!it_r.in_range) begin
            res_r       <= '0;
            res_valid_r <= 1'b1;
            state_r     <= B_IDLE;
          end else begin
            state_r <= B_CHECK;
          end
        end
        B_CHECK: begin
          if (dead) begin
            res_r       <= '0;
            res_valid_r <= 1'b1;
            state_r     <= B_IDLE;
          end else begin
            age_w_r <= sat32(age_dt);
            for (int i = 0; i < 3; i++) begin
              pos_r[i]  <= signed'(rd_pos_r[i*32 +: 32]);
              vel_r[i]  <= signed'(rd_vel_r[i*32 +: 32]);
              col_r[i]  <= signed'(rd_col_r[i*32 +: 32]);
              rate_r[i] <= signed'(rd_rate_r[i*32 +: 32]);
            end
            al_r    <= signed'(rd_alpha_r[31:0]);
            alr_r   <= signed'(rd_alpha_r[63:32]);
            sz_r    <= signed'(rd_size_r[31:0]);
            szr_r   <= signed'(rd_size_r[63:32]);
            stop_r  <= rd_flag_r[FLAG_STOP_BIT];
            sh_r    <= rd_flag_r[FLAG_SH_BIT];
            show_r  <= rd_flag_r[FLAG_SHOW_BIT];
            str_r   <= it_r.strength;
            op_r    <= OP_POS0;
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          prod_r  <= opa * opb;
          state_r <= B_ACC;
        end
        B_ACC: begin
          case (op_r) inside
            [OP_POS0:OP_POS2]:   pos_r[lane] <= sat32(ext35(pos_r[lane]) + mq35);
            [OP_DAMP0:OP_DAMP2]: begin
              if (stop_r) begin
                vel_r[lane] <= sat32(ext35(vel_r[lane]) - mq35);
              end
            end
            OP_STR_DAMP: begin
              if (stop_r) begin
                str_r <= sat32(ext35(str_r) - mq35);
              end
            end
            OP_K:                k_r <= mq_w[31:0];
            [OP_ATT0:OP_ATT2]:   vel_r[lane] <= sat32(ext35(vel_r[lane]) + mq35);
            [OP_COL0:OP_COL2]:   col_r[lane] <= sat32(ext35(col_r[lane]) + mq35);
            OP_ALPHA: begin
              al_r   <= alpha_nxt;
              show_r <= show_nxt;
            end
            OP_SIZE:             sz_r <= sat32(ext35(sz_r) + mq35);
            default: ;
          endcase
          // Pick the next step; the attractor steps run only when enabled.
          if (op_r == OP_SIZE) begin
            state_r <= B_WB;
          end else if (op_r == OP_K) begin
            if (it_r.att_en) begin
              op_r    <= OP_ATT0;
              state_r <= B_NORM_GO;
            end else begin
              op_r    <= OP_COL0;
              state_r <= B_MUL;
            end
          end else begin
            op_r    <= op_r + 1'b1;
            state_r <= B_MUL;
          end
        end
        B_NORM_GO: begin
          state_r <= B_NORM_WAIT;
        end
        B_NORM_WAIT: begin
          if (norm_done) begin
            u_r[0]  <= unit_x;
            u_r[1]  <= unit_y;
            u_r[2]  <= unit_z;
            state_r <= B_MUL;
          end
        end
        B_WB: begin
          res_r.alive   <= 1'b1;
          res_r.pos_x   <= pos_r[0];
          res_r.pos_y   <= pos_r[1];
          res_r.pos_z   <= pos_r[2];
          res_r.red     <= col_r[0];
          res_r.green   <= col_r[1];
          res_r.blue    <= col_r[2];
          res_r.opacity <= al_r;
          res_r.size    <= sz_r;
          res_valid_r   <= 1'b1;
          state_r       <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ===== rtl/particle_state_integrator_unit.sv =====
// Top level of the particle state integrator: front-end queue and back-end
// update engine. Depends on psi_pkg, psi_front and psi_back.
//
//   Channel  Handshake              Ports
//   input    start && !busy         in_command .. in_attract_strength
//   result   out_valid (one cycle)  out_alive .. out_particle_size
//
// In the back end a write item or an out-of-range update ends after the
// table fetch, an expiring update after the expiry check. A live update
// runs each product as a multiply and an accumulate step on the one shared
// multiplier; the normalizer's square root and dividers retire one bit a cycle.
// The two-entry queue takes items while the back end works; busy rises when
// it is full. Reset (rst_n low, synchronous) empties the queue and idles the
// engine; table contents are undefined until written. Results cannot be held.
module particle_state_integrator_unit import psi_pkg::*; #(
  parameter int NUM_PARTICLES = NUM_PARTICLES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_command,
  input  logic [7:0]         in_particle_index,
  input  logic [4:0]         in_field_select,
  input  logic signed [31:0] in_field_value,
  input  logic [15:0]        in_time_step,
  input  logic signed [31:0] in_attractor_x,
  input  logic signed [31:0] in_attractor_y,
  input  logic signed [31:0] in_attractor_z,
  input  logic               in_attract_enable,
  input  logic signed [31:0] in_attract_strength,
  output logic               out_valid,
  output logic               out_alive,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_red,
  output logic signed [31:0] out_green,
  output logic signed [31:0] out_blue,
  output logic signed [31:0] out_opacity,
  output logic signed [31:0] out_particle_size
);

  logic    q_valid;
  logic    pop;
  item_t   q_item;
  result_t res;

  // Item acceptance and queue.
  psi_front #(.NUM_PARTICLES(NUM_PARTICLES)) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_command          (in_command),
    .in_particle_index   (in_particle_index),
    .in_field_select     (in_field_select),
    .in_field_value      (in_field_value),
    .in_time_step        (in_time_step),
    .in_attractor_x      (in_attractor_x),
    .in_attractor_y      (in_attractor_y),
    .in_attractor_z      (in_attractor_z),
    .in_attract_enable   (in_attract_enable),
    .in_attract_strength (in_attract_strength),
    .pop                 (pop),
    .q_valid             (q_valid),
    .q_item              (q_item)
  );

  // Table storage and update engine.
  psi_back #(.NUM_PARTICLES(NUM_PARTICLES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .res_valid (out_valid),
    .res       (res)
  );

  assign out_alive         = res.alive;
  assign out_pos_x         = res.pos_x;
  assign out_pos_y         = res.pos_y;
  assign out_pos_z         = res.pos_z;
  assign out_red           = res.red;
  assign out_green         = res.green;
  assign out_blue          = res.blue;
  assign out_opacity       = res.opacity;
  assign out_particle_size = res.size;

`ifndef SYNTHESIS
  // The engine returns to idle after every result, so results never abut.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // A dead or out-of-range particle reports all-zero fields.
  a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_alive |-> out_pos_x == 0 && out_red == 0 &&
    out_opacity == 0 && out_particle_size == 0)
    else $error("expired particle with nonzero result fields");

  // Reset empties the queue and drops any pending result.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("queue or result not cleared by reset");
`endif

endmodule

// ===== tb/particle_state_integrator_unit_test.sv =====
// Self-checking testbench for particle_state_integrator_unit: a directed table, then random
// write and update items, checked against a fixed-point predictor of the particle table.
// Depends on psi_pkg and particle_state_integrator_unit.
module particle_state_integrator_unit_test;
  import psi_pkg::*;

  localparam logic [4:0] F_FIRST_UNUSED = 5'd22;
  localparam int NUM_FIELDS = 18;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic              command;
    logic [7:0]        index;
    logic [4:0]        sel;
    logic signed [31:0] value;
    logic [15:0]       step;
    logic signed [31:0] att_x;
    logic signed [31:0] att_y;
    logic signed [31:0] att_z;
    logic              att_en;
    logic signed [31:0] strength;
  } particle_cmd_t;

  typedef enum {ROW_LOAD, ROW_WRITE, ROW_UPDATE} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    particle_cmd_t     cmd;
    bit                expires;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_command = CMD_WRITE;
  logic [7:0] in_particle_index = '0;
  logic [4:0] in_field_select = '0;
  logic signed [31:0] in_field_value = '0;
  logic [15:0] in_time_step = '0;
  logic signed [31:0] in_attractor_x = '0;
  logic signed [31:0] in_attractor_y = '0;
  logic signed [31:0] in_attractor_z = '0;
  logic in_attract_enable = 1'b0;
  logic signed [31:0] in_attract_strength = '0;
  logic out_valid;
  logic out_alive;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [31:0] out_red, out_green, out_blue;
  logic signed [31:0] out_opacity, out_particle_size;

  particle_state_integrator_unit dut (.*);

  // Clock with a period of 10 units.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted contents of the particle table.
  int age_mem[256];
  int life_mem[256];
  int pos_mem[256][3];
  int vel_mem[256][3];
  int col_mem[256][3];
  int col_rate_mem[256][3];
  int alpha_mem[256];
  int alpha_rate_mem[256];
  int size_mem[256];
  int size_rate_mem[256];
  logic [2:0] flag_mem[256];
  bit loaded[256];

  result_t pending_results[$];
  int items_sent = 0;
  int updates_sent = 0;
  int results_seen = 0;
  int errors = 0;
  bit idle_on = 1'b1;

  // Saturate to the signed 32-bit range.
  function automatic int clamp_word(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  // Q16.16 product rounded toward minus infinity.
  function automatic longint scale_q(input longint a, input longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Apply a write item to the predicted table.
  function automatic void store_field(input particle_cmd_t c);
    int p = c.index;
    int v = c.value;
    case (c.sel) inside
      F_AGE: age_mem[p] = v;
      F_LIFE: life_mem[p] = v;
      [F_POS_X:F_POS_Z]: pos_mem[p][c.sel - F_POS_X] = v;
      [F_VEL_X:F_VEL_Z]: vel_mem[p][c.sel - F_VEL_X] = v;
      [F_COL_R:F_COL_B]: col_mem[p][c.sel - F_COL_R] = v;
      [F_RATE_R:F_RATE_B]: col_rate_mem[p][c.sel - F_RATE_R] = v;
      F_ALPHA: alpha_mem[p] = v;
      F_ALPHA_RATE: alpha_rate_mem[p] = v;
      F_SIZE: size_mem[p] = v;
      F_SIZE_RATE: size_rate_mem[p] = v;
      F_STOP: flag_mem[p][FLAG_STOP_BIT] = c.value[0];
      F_SHOW_HIDE: flag_mem[p][FLAG_SH_BIT] = c.value[0];
      F_SHOW: flag_mem[p][FLAG_SHOW_BIT] = c.value[0];
      F_FLAGS: flag_mem[p] = c.value[2:0];
      default: ;
    endcase
  endfunction

  // Advance one particle by its step and return the result it reports.
  function automatic result_t advance_particle(input particle_cmd_t c);
    result_t r = '0;
    int p = c.index;
    longint dt = c.step;
    longint strength = c.strength;
    longint a, k, len;
    longint d[3];
    longint unsigned m[3];
    longint u[3];
    logic [2:0] fl = flag_mem[p];
    bit stop = fl[FLAG_STOP_BIT];
    bit halve = 1'b0;
    if (longint'(age_mem[p]) + dt >= longint'(life_mem[p])) begin
      age_mem[p] = -ONE_Q;
      return r;
    end
    age_mem[p] = clamp_word(longint'(age_mem[p]) + dt);
    for (int i = 0; i < 3; i++)
      pos_mem[p][i] = clamp_word(longint'(pos_mem[p][i]) + scale_q(vel_mem[p][i], dt));
    if (stop)
      for (int i = 0; i < 3; i++)
        vel_mem[p][i] = clamp_word(longint'(vel_mem[p][i]) - scale_q(vel_mem[p][i], dt));
    // Pull toward the attractor along the unit direction.
    if (c.att_en) begin
      d[0] = longint'(c.att_x) - pos_mem[p][0];
      d[1] = longint'(c.att_y) - pos_mem[p][1];
      d[2] = longint'(c.att_z) - pos_mem[p][2];
      if (stop) strength = clamp_word(strength - scale_q(strength, dt));
      for (int i = 0; i < 3; i++) begin
        m[i] = d[i] < 0 ? -d[i] : d[i];
        if (m[i] >= 64'd2147483648) halve = 1'b1;
      end
      if (halve)
        for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      len = root_floor(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      for (int i = 0; i < 3; i++) begin
        u[i] = (len == 0) ? 0 : longint'((m[i] << 16) / len);
        if (d[i] < 0) u[i] = -u[i];
      end
      k = scale_q(strength, dt);
      for (int i = 0; i < 3; i++)
        vel_mem[p][i] = clamp_word(longint'(vel_mem[p][i]) + scale_q(u[i], k));
    end
    for (int i = 0; i < 3; i++)
      col_mem[p][i] = clamp_word(longint'(col_mem[p][i]) + scale_q(col_rate_mem[p][i], dt));
    // Alpha: free running, or the rise-then-fall of show-hide mode.
    k = scale_q(alpha_rate_mem[p], dt);
    a = alpha_mem[p];
    if (!fl[FLAG_SH_BIT]) begin
      alpha_mem[p] = clamp_word(a + k);
    end else begin
      if (fl[FLAG_SHOW_BIT]) begin
        a = clamp_word(a + k);
        if (a >= ONE_Q) begin
          a = ONE_Q;
          fl[FLAG_SHOW_BIT] = 1'b0;
        end
      end else begin
        a = clamp_word(a - k);
      end
      if (a < 0) a = 0;
      if (a > ONE_Q) a = ONE_Q;
      alpha_mem[p] = int'(a);
      flag_mem[p] = fl;
    end
    size_mem[p] = clamp_word(longint'(size_mem[p]) + scale_q(size_rate_mem[p], dt));
    r.alive = 1'b1;
    r.pos_x = pos_mem[p][0];
    r.pos_y = pos_mem[p][1];
    r.pos_z = pos_mem[p][2];
    r.red = col_mem[p][0];
    r.green = col_mem[p][1];
    r.blue = col_mem[p][2];
    r.opacity = alpha_mem[p];
    r.size = size_mem[p];
    return r;
  endfunction

  // Drive one item, wait for its acceptance, then record what it should produce.
  task automatic issue(input particle_cmd_t c, input bit expires = 1'b0);
    result_t r;
    in_command <= c.command;
    in_particle_index <= c.index;
    in_field_select <= c.sel;
    in_field_value <= c.value;
    in_time_step <= c.step;
    in_attractor_x <= c.att_x;
    in_attractor_y <= c.att_y;
    in_attractor_z <= c.att_z;
    in_attract_enable <= c.att_en;
    in_attract_strength <= c.strength;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
    if (c.command == CMD_WRITE) begin
      store_field(c);
    end else begin
      updates_sent++;
      r = advance_particle(c);
      // An expiring update reports dead with every other field zero.
      if (expires) r = '0;
      pending_results.push_back(r);
    end
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] random_q();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fff_ffff - $urandom_range(0, 3)
                                     : 32'sh8000_0000 + $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000;
    endcase
  endfunction

  function automatic logic [15:0] random_step();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Write every field of a particle so that it may be updated.
  task automatic load_particle(input logic [7:0] p, input bit use_fill,
                               input logic signed [31:0] fill, input logic [2:0] flags,
                               input logic signed [31:0] life);
    particle_cmd_t c;
    c = '{default: '0};
    c.command = CMD_WRITE;
    c.index = p;
    for (int f = 0; f < NUM_FIELDS; f++) begin
      c.sel = f[4:0];
      c.value = use_fill ? fill : random_q();
      if (c.sel == F_AGE) c.value = 0;
      if (c.sel == F_LIFE) c.value = life;
      issue(c);
    end
    c.sel = F_FLAGS;
    c.value = {$urandom} & ~32'h7 | flags;
    issue(c);
    loaded[p] = 1'b1;
  endtask

  function automatic particle_cmd_t make_update(input logic [7:0] p, input logic [15:0] dt,
                                                input logic en, input logic signed [31:0] ax,
                                                input logic signed [31:0] st);
    particle_cmd_t c;
    c = '{default: '0};
    c.command = CMD_UPDATE;
    c.index = p;
    c.step = dt;
    c.att_en = en;
    c.att_x = ax;
    c.att_y = ax;
    c.att_z = ax;
    c.strength = st;
    c.sel = 5'($urandom);
    c.value = $urandom;
    return c;
  endfunction

  function automatic particle_cmd_t make_write(input logic [7:0] p, input logic [4:0] sel,
                                               input logic signed [31:0] v);
    particle_cmd_t c;
    c = '{default: '0};
    c.command = CMD_WRITE;
    c.index = p;
    c.sel = sel;
    c.value = v;
    c.step = 16'($urandom);
    return c;
  endfunction

  task automatic check_word(input string name, input logic signed [31:0] exp_v,
                            input logic signed [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch on %s: expected %h, got %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Compare each result item with the oldest expectation.
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item, alive %b pos_x %h", $time, out_alive, out_pos_x);
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_word("alive", 32'(e.alive), 32'(out_alive));
        check_word("pos_x", e.pos_x, out_pos_x);
        check_word("pos_y", e.pos_y, out_pos_y);
        check_word("pos_z", e.pos_z, out_pos_z);
        check_word("red", e.red, out_red);
        check_word("green", e.green, out_green);
        check_word("blue", e.blue, out_blue);
        check_word("opacity", e.opacity, out_opacity);
        check_word("particle_size", e.size, out_particle_size);
      end
    end
  end

  // Run limit.
  initial begin
    #10_000_000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    particle_cmd_t c;
    logic [7:0] p;
    int pick;

    // Directed table: loads with extreme contents, saturation, attractor corners,
    // expiry, unused field selects and the show-hide alpha ramp.
    rows.push_back('{ROW_LOAD, make_write(8'd0, 5'd0, ONE_Q), 1'b0});
    rows.push_back('{ROW_UPDATE, make_update(8'd0, 16'hffff, 1'b0, 0, 0), 1'b0});
    rows.push_back('{ROW_UPDATE, make_update(8'd0, 16'hffff, 1'b1, 32'sh7fff_ffff,
                                             32'sh7fff_ffff), 1'b0});
    rows.push_back('{ROW_LOAD, make_write(8'd255, 5'd7, 32'sh7fff_ffff), 1'b0});
    rows.push_back('{ROW_UPDATE, make_update(8'd255, 16'hffff, 1'b1, 32'sh8000_0000,
                                             ONE_Q), 1'b0});
    // Attractor on top of the saturated position: zero direction.
    rows.push_back('{ROW_UPDATE, make_update(8'd255, 16'h8000, 1'b1, 32'sh7fff_ffff,
                                             ONE_Q), 1'b0});
    rows.push_back('{ROW_LOAD, make_write(8'd2, 5'd3, 32'sh8000_0000), 1'b0});
    rows.push_back('{ROW_UPDATE, make_update(8'd2, 16'hffff, 1'b1, 32'sh7fff_ffff,
                                             32'sh8000_0000), 1'b0});
    rows.push_back('{ROW_WRITE, make_write(8'd2, F_AGE, 32'sh7fff_0000), 1'b0});
    rows.push_back('{ROW_UPDATE, make_update(8'd2, 16'hffff, 1'b0, 0, 0), 1'b1});
    rows.push_back('{ROW_UPDATE, make_update(8'd2, 16'h0001, 1'b0, 0, 0), 1'b0});
    rows.push_back('{ROW_WRITE, make_write(8'd2, F_FIRST_UNUSED, 32'sh1234_5678), 1'b0});
    rows.push_back('{ROW_WRITE, make_write(8'd2, 5'd31, 32'shffff_ffff), 1'b0});
    rows.push_back('{ROW_UPDATE, make_update(8'd2, 16'h0100, 1'b0, 0, 0), 1'b0});
    rows.push_back('{ROW_LOAD, make_write(8'd3, 5'd5, -ONE_Q), 1'b0});
    rows.push_back('{ROW_WRITE, make_write(8'd3, F_LIFE, 0), 1'b0});
    rows.push_back('{ROW_UPDATE, make_update(8'd3, 16'h0000, 1'b0, 0, 0), 1'b1});
    rows.push_back('{ROW_WRITE, make_write(8'd0, F_ALPHA, 0), 1'b0});
    rows.push_back('{ROW_WRITE, make_write(8'd0, F_ALPHA_RATE, 32'sh0002_0000), 1'b0});
    rows.push_back('{ROW_WRITE, make_write(8'd0, F_SHOW_HIDE, 32'sh0000_0001), 1'b0});
    rows.push_back('{ROW_WRITE, make_write(8'd0, F_SHOW, 32'sh0000_0001), 1'b0});
    rows.push_back('{ROW_WRITE, make_write(8'd0, F_STOP, 32'shffff_ffff), 1'b0});
    rows.push_back('{ROW_UPDATE, make_update(8'd0, 16'h4000, 1'b0, 0, 0), 1'b0});
    rows.push_back('{ROW_UPDATE, make_update(8'd0, 16'hc000, 1'b0, 0, 0), 1'b0});
    rows.push_back('{ROW_UPDATE, make_update(8'd0, 16'h4000, 1'b1, 0, 32'sh0010_0000), 1'b0});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_LOAD)
        load_particle(rows[i].cmd.index, 1'b1, rows[i].cmd.value, rows[i].cmd.sel[2:0],
                      32'sh7fff_ffff);
      else
        issue(rows[i].cmd, rows[i].expires);
    end

    // Random part: mostly updates of loaded particles, with field writes and reloads.
    while (items_sent < 700) begin
      if (items_sent > 560) idle_on = 1'b0;
      if (items_sent > 300 && items_sent < 320) begin
        start <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);
      end
      p = $urandom_range(0, 7) == 0 ? 8'($urandom) : 8'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (!loaded[p] || pick < 6) begin
        load_particle(p, 1'b0, 0, 3'($urandom),
                      $signed($urandom_range(1, 48)) <<< 16);
      end else if (pick < 30) begin
        c = make_write(p, 5'($urandom), random_q());
        if ($urandom_range(0, 3) == 0) c.value = $urandom;
        issue(c);
      end else begin
        c = make_update(p, random_step(), 1'($urandom), 0, random_q());
        c.att_x = random_q();
        c.att_y = random_q();
        c.att_z = random_q();
        issue(c);
      end
    end
    start <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items (%0d updates), checked %0d results.",
             items_sent, updates_sent, results_seen);
    $display("Covered saturation, attractor pull, expiry, show-hide alpha and ignored writes.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== particle_state_integrator_unit.f =====
rtl/psi_pkg.sv
rtl/psi_front.sv
rtl/psi_norm.sv
rtl/psi_back.sv
rtl/particle_state_integrator_unit.sv
tb/particle_state_integrator_unit_test.sv
